/* design/rhav_pkg.sv */
// Package for the approximate RGB to HSV converter.
// Holds the shared constants, the sideband item type and the divider step.
// Depends on nothing.
`default_nettype none

package rhav_pkg;

   localparam int unsigned COMP_W = 8;
   localparam int unsigned NUM_W = 2 * COMP_W;

   localparam logic [NUM_W-1:0]  HUE_STEP = 16'd43;
   localparam logic [NUM_W-1:0]  FULL_SCALE = 16'd255;
   localparam logic [COMP_W-1:0] HUE_BASE_RED = 8'd0;
   localparam logic [COMP_W-1:0] HUE_BASE_GREEN = 8'd85;
   localparam logic [COMP_W-1:0] HUE_BASE_BLUE = 8'd171;

   // Quotient bits resolved in each divider stage.
   localparam int unsigned STEPS_PER_STAGE = 2;
   localparam int unsigned DIV_STAGES = COMP_W / STEPS_PER_STAGE;
   // Two front-end stages, the divider stages and the output register.
   localparam int unsigned PIPE_DEPTH = DIV_STAGES + 3;

   typedef struct packed {
      logic [COMP_W-1:0] bright;
      logic [COMP_W-1:0] base;
      logic              neg;
      logic              zero;
   } rhav_side_type;

   // One restoring division step. The word holds the partial remainder in
   // its upper half and the unshifted numerator bits, then the quotient
   // bits, in its lower half.
   function automatic logic [NUM_W-1:0] div_step(input logic [NUM_W-1:0] w,
                                                 input logic [COMP_W-1:0] d);
      logic [COMP_W:0] trial;
      logic [COMP_W:0] diff;
      trial = w[NUM_W-1:COMP_W-1];
      diff = trial - {1'b0, d};
      if (trial >= {1'b0, d}) begin
         div_step = {diff[COMP_W-1:0], w[COMP_W-2:0], 1'b1};
      end else begin
         div_step = {trial[COMP_W-1:0], w[COMP_W-2:0], 1'b0};
      end
   endfunction

endpackage

`default_nettype wire

/* design/rhav_prep.sv */
// Front end of the converter: max/min search, hue sector choice and the two
// division numerators, over two register stages. Uses rhav_pkg.
`default_nettype none

module rhav_prep (
   input  wire logic                         clock,
   input  wire logic [1:0]                   en,
   input  wire logic [rhav_pkg::COMP_W-1:0]  red,
   input  wire logic [rhav_pkg::COMP_W-1:0]  green,
   input  wire logic [rhav_pkg::COMP_W-1:0]  blue,
   output logic      [rhav_pkg::NUM_W-1:0]   sat_num,
   output logic      [rhav_pkg::COMP_W-1:0]  sat_den,
   output logic      [rhav_pkg::NUM_W-1:0]   hue_num,
   output logic      [rhav_pkg::COMP_W-1:0]  hue_den,
   output rhav_pkg::rhav_side_type           side
);

   logic [rhav_pkg::COMP_W-1:0] mx, mn, pa, pb, base;
   logic [rhav_pkg::COMP_W:0]   diff;

   logic [rhav_pkg::COMP_W-1:0] bright_ff, delta_ff, mag_ff, base_ff;
   logic                        neg_ff;

   logic [rhav_pkg::NUM_W-1:0]  sat_num_ff, hue_num_ff;
   logic [rhav_pkg::COMP_W-1:0] sat_den_ff, hue_den_ff;
   rhav_pkg::rhav_side_type     side_ff, side_in;

   // Red wins ties, then green. The two other components give the hue offset.
   always_comb begin
      if (red >= green && red >= blue) begin
         mx = red;
         pa = green;
         pb = blue;
         base = rhav_pkg::HUE_BASE_RED;
      end else if (green >= blue) begin
         mx = green;
         pa = blue;
         pb = red;
         base = rhav_pkg::HUE_BASE_GREEN;
      end else begin
         mx = blue;
         pa = red;
         pb = green;
         base = rhav_pkg::HUE_BASE_BLUE;
      end
      mn = red;
      if (green < mn) begin
         mn = green;
      end
      if (blue < mn) begin
         mn = blue;
      end
      diff = {1'b0, pa} - {1'b0, pb};
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         bright_ff <= mx;
         delta_ff <= mx - mn;
         neg_ff <= diff[rhav_pkg::COMP_W];
         mag_ff <= diff[rhav_pkg::COMP_W] ? (pb - pa) : diff[rhav_pkg::COMP_W-1:0];
         base_ff <= base;
      end
   end

   always_comb begin
      side_in.bright = bright_ff;
      side_in.base = base_ff;
      side_in.neg = neg_ff;
      // A zero delta covers both the grey and the black pixel.
      side_in.zero = (delta_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         sat_num_ff <= rhav_pkg::NUM_W'(rhav_pkg::NUM_W'(delta_ff) * rhav_pkg::FULL_SCALE);
         hue_num_ff <= rhav_pkg::NUM_W'(rhav_pkg::NUM_W'(mag_ff) * rhav_pkg::HUE_STEP);
         sat_den_ff <= bright_ff;
         hue_den_ff <= delta_ff;
         side_ff <= side_in;
      end
   end

   assign sat_num = sat_num_ff;
   assign sat_den = sat_den_ff;
   assign hue_num = hue_num_ff;
   assign hue_den = hue_den_ff;
   assign side = side_ff;

endmodule

`default_nettype wire

/* design/rhav_div.sv */
// Pipelined restoring divider: 16-bit numerator by 8-bit divisor, 8-bit
// quotient, a fixed number of quotient bits per stage. Uses rhav_pkg.
`default_nettype none

module rhav_div (
   input  wire logic                               clock,
   input  wire logic [rhav_pkg::DIV_STAGES-1:0]    en,
   input  wire logic [rhav_pkg::NUM_W-1:0]         num,
   input  wire logic [rhav_pkg::COMP_W-1:0]        den,
   output logic      [rhav_pkg::COMP_W-1:0]        quot
);

   // For a nonzero den the numerator is below den * 256, so eight steps give the quotient.
   logic [rhav_pkg::NUM_W-1:0]  w_ff [rhav_pkg::DIV_STAGES];
   logic [rhav_pkg::COMP_W-1:0] d_ff [rhav_pkg::DIV_STAGES];

   for (genvar k = 0; k < rhav_pkg::DIV_STAGES; k++) begin : g_stage
      logic [rhav_pkg::NUM_W-1:0]  src_w;
      logic [rhav_pkg::COMP_W-1:0] src_d;
      logic [rhav_pkg::NUM_W-1:0]  w_in;

      if (k == 0) begin : g_first
         assign src_w = num;
         assign src_d = den;
      end else begin : g_next
         assign src_w = w_ff[k-1];
         assign src_d = d_ff[k-1];
      end

      always_comb begin
         w_in = src_w;
         for (int s = 0; s < rhav_pkg::STEPS_PER_STAGE; s++) begin
            w_in = rhav_pkg::div_step(w_in, src_d);
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            w_ff[k] <= w_in;
            d_ff[k] <= src_d;
         end
      end
   end

   assign quot = w_ff[rhav_pkg::DIV_STAGES-1][rhav_pkg::COMP_W-1:0];

endmodule

`default_nettype wire

/* design/rgb_to_hsv_approx_8bit_core.sv */
// Top level of the approximate RGB to HSV converter.
// Uses rhav_pkg, rhav_prep and rhav_div.
//
// Converts one 8-bit RGB pixel per clock into an 8-bit HSV triple while the
// result side does not stall. Every stage takes a new item each cycle unless
// back-pressure holds its item; an item passes seven register stages: two
// front-end stages (max/min and the numerators), four divider stages
// resolving two quotient bits each for saturation and hue in parallel,
// and the output register. Each stage keeps its own valid bit, so
// a stalled result does not block the stages behind it until they fill.
// Brightness is the largest component, saturation is delta*255/brightness,
// and hue is the sector base 0, 85 or 171 plus the signed offset times 43
// over delta, truncated toward zero, modulo 256. Grey and black pixels give
// hue 0 and saturation 0. Red wins ties, then green.
`default_nettype none

module rgb_to_hsv_approx_8bit_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata    // hue [7:0], saturation [15:8], brightness [23:16]
);

   localparam int unsigned W = rhav_pkg::COMP_W;

   logic [rhav_pkg::PIPE_DEPTH-1:0] valid_ff;
   logic [rhav_pkg::PIPE_DEPTH-1:0] ready;

   logic [rhav_pkg::NUM_W-1:0] sat_num, hue_num;
   logic [W-1:0]               sat_den, hue_den, sat_q, hue_q, hue_in, sat_in;
   rhav_pkg::rhav_side_type    prep_side;
   rhav_pkg::rhav_side_type    side_ff [rhav_pkg::DIV_STAGES];

   logic [W-1:0] hue_ff, sat_ff, bright_ff;

   // A stage may load when it is empty or its item moves on in this cycle.
   always_comb begin
      ready[rhav_pkg::PIPE_DEPTH-1] = !valid_ff[rhav_pkg::PIPE_DEPTH-1] || rsp_tready;
      for (int k = rhav_pkg::PIPE_DEPTH - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < rhav_pkg::PIPE_DEPTH; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   rhav_prep u_prep (
      .clock   (clock),
      .en      (ready[1:0]),
      .red     (req_tdata[W-1:0]),
      .green   (req_tdata[2*W-1:W]),
      .blue    (req_tdata[3*W-1:2*W]),
      .sat_num (sat_num),
      .sat_den (sat_den),
      .hue_num (hue_num),
      .hue_den (hue_den),
      .side    (prep_side)
   );

   rhav_div u_div_sat (
      .clock (clock),
      .en    (ready[rhav_pkg::DIV_STAGES+1:2]),
      .num   (sat_num),
      .den   (sat_den),
      .quot  (sat_q)
   );

   rhav_div u_div_hue (
      .clock (clock),
      .en    (ready[rhav_pkg::DIV_STAGES+1:2]),
      .num   (hue_num),
      .den   (hue_den),
      .quot  (hue_q)
   );

   // Sideband travels alongside the divider stages.
   always_ff @(posedge clock) begin
      if (ready[2]) begin
         side_ff[0] <= prep_side;
      end
      for (int k = 1; k < rhav_pkg::DIV_STAGES; k++) begin
         if (ready[k+2]) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   always_comb begin
      if (side_ff[rhav_pkg::DIV_STAGES-1].zero) begin
         hue_in = '0;
         sat_in = '0;
      end else begin
         // Negative offsets are truncated toward zero, then wrap with the base.
         hue_in = side_ff[rhav_pkg::DIV_STAGES-1].neg
                  ? side_ff[rhav_pkg::DIV_STAGES-1].base - hue_q
                  : side_ff[rhav_pkg::DIV_STAGES-1].base + hue_q;
         sat_in = sat_q;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[rhav_pkg::PIPE_DEPTH-1]) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         bright_ff <= side_ff[rhav_pkg::DIV_STAGES-1].bright;
      end
   end

   assign req_tready = ready[0];
   assign rsp_tvalid = valid_ff[rhav_pkg::PIPE_DEPTH-1];
   assign rsp_tdata = {bright_ff, sat_ff, hue_ff};

endmodule

`default_nettype wire

/* tb/rhav_checker.sv */
// Result checker for the approximate RGB to HSV converter.
// Watches both stream channels, predicts each result and compares it.
// Depends on nothing but the channel signals of rgb_to_hsv_approx_8bit_core.

module rhav_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [23:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,   // hue [7:0], saturation [15:8], brightness [23:16]
   output int               error_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SECTOR_STEP = 43;
   localparam int GREEN_BASE = 85;
   localparam int BLUE_BASE = 171;
   localparam int SAT_SCALE = 255;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0] brightness;
      logic [7:0] saturation;
      logic [7:0] hue;
   } hsv_type;

   hsv_type expected_hsv[$];

   function automatic hsv_type hsv_of_pixel(input logic [23:0] px);
      int      r, g, b, peak, trough, delta, h;
      hsv_type res;
      r = int'(px[7:0]);
      g = int'(px[15:8]);
      b = int'(px[23:16]);
      peak = r;
      trough = r;
      if (g > peak) peak = g;
      if (b > peak) peak = b;
      if (g < trough) trough = g;
      if (b < trough) trough = b;
      delta = peak - trough;
      res = '0;
      res.brightness = peak[7:0];
      // Black and grey pixels keep hue and saturation at zero.
      if (peak != 0 && delta != 0) begin
         res.saturation = 8'((delta * SAT_SCALE) / peak);
         // Signed int division truncates toward zero; red wins ties, then green.
         if (peak == r) begin
            h = ((g - b) * SECTOR_STEP) / delta;
         end else if (peak == g) begin
            h = GREEN_BASE + ((b - r) * SECTOR_STEP) / delta;
         end else begin
            h = BLUE_BASE + ((r - g) * SECTOR_STEP) / delta;
         end
         res.hue = h[7:0];
      end
      return res;
   endfunction

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("%0t ns: %s", $realtime, msg);
   endtask

   initial begin
      error_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      hsv_type got;
      hsv_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_hsv.size() == 0) begin
               note_error($sformatf("unexpected result item h=%0d s=%0d v=%0d",
                                    got.hue, got.saturation, got.brightness));
            end else begin
               want = expected_hsv.pop_front();
               if (got.hue !== want.hue || got.saturation !== want.saturation ||
                   got.brightness !== want.brightness) begin
                  note_error($sformatf({"result mismatch: hue exp %0d got %0d, ",
                                        "sat exp %0d got %0d, val exp %0d got %0d"},
                                       want.hue, got.hue, want.saturation,
                                       got.saturation, want.brightness,
                                       got.brightness));
               end
            end
         end
         if (req_tvalid && req_tready) expected_hsv.push_back(hsv_of_pixel(req_tdata));
      end
      pending = expected_hsv.size();
   end

endmodule

/* tb/tb_rgb_to_hsv_approx_8bit_core.sv */
// Top of the testbench for rgb_to_hsv_approx_8bit_core.
// Drives pixel items with random gaps and back-pressure; rhav_checker judges results.
// Depends on rhav_pkg, the converter RTL and rhav_checker.

module tb_rgb_to_hsv_approx_8bit_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1000;
   localparam int HOLD_AT = 300;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT = 5000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // red [7:0], green [15:8], blue [23:16]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // hue [7:0], saturation [15:8], brightness [23:16]

   int error_count;
   int pending;
   int sent_count = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;

   rgb_to_hsv_approx_8bit_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   rhav_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .error_count (error_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [23:0] pixel(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
      return {b, g, r};
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(2))
         0: return 0;
         1: return 15;
         default: return 50;
      endcase
   endfunction

   // Most gaps are a few cycles; now and then a long one.
   function automatic int gap_len();
      if ($urandom_range(9) == 0) return $urandom_range(80, 20);
      return $urandom_range(3, 1);
   endfunction

   function automatic logic [7:0] extreme_comp();
      case ($urandom_range(3))
         0: return 8'd0;
         1: return 8'd1;
         2: return 8'd254;
         default: return 8'd255;
      endcase
   endfunction

   function automatic logic [23:0] random_pixel();
      logic [7:0] r, g, b;
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      case ($urandom_range(9))
         6: g = r;
         7: begin
            case ($urandom_range(2))
               0: b = r;
               1: b = g;
               default: begin
                  g = r;
                  b = r;
               end
            endcase
         end
         8: begin
            r = 8'($urandom_range(3));
            g = 8'($urandom_range(3));
            b = 8'($urandom_range(3));
         end
         9: begin
            r = extreme_comp();
            g = extreme_comp();
            b = extreme_comp();
         end
         default: ;
      endcase
      return pixel(r, g, b);
   endfunction

   task automatic send_pixel(input logic [23:0] px);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? gap_len() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   // Stop offering items until every result in flight has been taken.
   task automatic pause_until_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending == 0);
   endtask

   // Receiver side: random ready gaps, plus one long hold-off while items keep coming.
   initial begin
      int  stall_left;
      int  phase_cycles;
      int  idle_pct;
      bit  hold_done;
      stall_left = 0;
      phase_cycles = 0;
      idle_pct = 0;
      hold_done = 1'b0;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (phase_cycles == 0) begin
            phase_cycles = 64;
            idle_pct = pick_idle_pct();
         end
         phase_cycles--;
         if (!hold_done && sent_count >= HOLD_AT) begin
            hold_done = 1'b1;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(99) < idle_pct) begin
            rsp_tready <= 1'b0;
            stall_left = gap_len() - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_rgb_to_hsv_approx_8bit_core: FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Black, white, grey, primaries, ties and the hue wrap around zero.
      send_pixel(pixel(8'd0, 8'd0, 8'd0));
      send_pixel(pixel(8'd255, 8'd255, 8'd255));
      send_pixel(pixel(8'd128, 8'd128, 8'd128));
      send_pixel(pixel(8'd255, 8'd0, 8'd0));
      send_pixel(pixel(8'd0, 8'd255, 8'd0));
      send_pixel(pixel(8'd0, 8'd0, 8'd255));
      send_pixel(pixel(8'd255, 8'd255, 8'd0));
      send_pixel(pixel(8'd0, 8'd255, 8'd255));
      send_pixel(pixel(8'd255, 8'd0, 8'd255));
      send_pixel(pixel(8'd1, 8'd0, 8'd0));
      send_pixel(pixel(8'd0, 8'd0, 8'd1));
      send_pixel(pixel(8'd1, 8'd1, 8'd0));
      send_pixel(pixel(8'd255, 8'd0, 8'd1));
      send_pixel(pixel(8'd255, 8'd0, 8'd200));
      send_pixel(pixel(8'd200, 8'd255, 8'd0));
      send_pixel(pixel(8'd0, 8'd200, 8'd255));
      send_pixel(pixel(8'd255, 8'd1, 8'd1));
      send_pixel(pixel(8'd254, 8'd255, 8'd0));
      send_pixel(pixel(8'd255, 8'd254, 8'd253));
      send_pixel(pixel(8'd170, 8'd85, 8'd255));
      pause_until_drained();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 50 == 0) send_idle_pct = pick_idle_pct();
         if (i == RANDOM_ITEMS / 2) pause_until_drained();
         send_pixel(random_pixel());
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      wait (pending == 0);
      repeat (rhav_pkg::PIPE_DEPTH + 4) @(posedge clock);
      if (error_count == 0 && pending == 0) begin
         $display("tb_rgb_to_hsv_approx_8bit_core: PASS");
      end else begin
         $display("tb_rgb_to_hsv_approx_8bit_core: FAIL");
      end
      $finish;
   end

endmodule
